[sv/cel_pkg.sv]
package cel_pkg;

	localparam int FracBits = 16;
	localparam int ValW = 32;
	localparam int StepW = 31;
	localparam int RadW = 64;
	localparam int RootW = 32;
	localparam int RemW = 35;
	localparam logic [StepW-1:0] StepReset = 31'd6554;
	localparam logic signed [64:0] Max32 = 65'sd2147483647;
	localparam logic signed [64:0] Min32 = -65'sd2147483648;

	typedef struct packed {
		logic signed [ValW-1:0] self_old;
		logic signed [ValW-1:0] center_old;
		logic signed [ValW-1:0] center_half;
		logic signed [ValW-1:0] opposite_old;
		logic signed [ValW-1:0] offset_x;
		logic signed [ValW-1:0] offset_y;
		logic signed [ValW-1:0] velocity_x;
		logic signed [ValW-1:0] velocity_y;
		logic signed [ValW-1:0] direction_x;
		logic signed [ValW-1:0] direction_y;
		logic                   limit_enable;
	} cel_req_t;

	typedef struct packed {
		logic signed [ValW-1:0] new_value;
		logic                   clamped;
		logic                   zero_distance;
	} cel_res_t;

	typedef struct packed {
		logic signed [ValW-1:0] self_old;
		logic signed [ValW-1:0] center_old;
		logic signed [ValW-1:0] center_half;
		logic signed [ValW-1:0] opposite_old;
		logic                   limit_enable;
	} cel_vals_t;

	typedef struct packed {
		cel_vals_t       vals;
		logic [RadW-1:0] dmag;
		logic            cneg;
	} cel_root_side_t;

	typedef struct packed {
		cel_vals_t vals;
		logic      cneg;
		logic      ovf;
		logic      zero;
	} cel_div_side_t;

	typedef struct packed {
		cel_div_side_t    side;
		logic [RootW-1:0] quot;
	} cel_quot_t;

	function automatic logic signed [64:0] shr_trunc(input logic signed [64:0] x);
		logic signed [64:0] bias;
		bias = x[64] ? 65'((65'sd1 <<< FracBits) - 65'sd1) : 65'sd0;
		return (x + bias) >>> FracBits;
	endfunction

	function automatic logic signed [ValW-1:0] sat32(input logic signed [64:0] x);
		logic signed [64:0] r;
		if (x > Max32) begin
			r = Max32;
		end else if (x < Min32) begin
			r = Min32;
		end else begin
			r = x;
		end
		return r[ValW-1:0];
	endfunction

endpackage

[sv/characteristic_extrapolation_limiter_core.sv]
// Throughput: one request per cycle; busy is always low.
// Latency is set by the front stages, the 32-stage square root, the 33-stage divider and the back stages.
// The receiver cannot stall: each result shows for one cycle with done.
// Reset clears all valid bits and loads step_q with 6554.
module characteristic_extrapolation_limiter_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cel_pkg::StepW-1:0] cfg_wdata,
	input  logic                      start,
	output logic                      busy,
	input  cel_pkg::cel_req_t         req,
	output logic                      done,
	output cel_pkg::cel_res_t         res
);

	logic [cel_pkg::StepW-1:0] step_q;
	logic f_valid, r_valid, d_valid;
	logic [cel_pkg::RadW-1:0] rad;
	logic [cel_pkg::RootW-1:0] root;
	cel_pkg::cel_root_side_t f_side, r_side;
	cel_pkg::cel_quot_t quot;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cel_pkg::StepReset;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	cel_front u_front (
		.clk(clk), .arst_n(arst_n), .valid_in(start && !busy), .req(req), .step(step_q),
		.valid_out(f_valid), .rad_out(rad), .side_out(f_side)
	);

	cel_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .valid_in(f_valid), .rad(rad), .side_in(f_side),
		.valid_out(r_valid), .root_out(root), .side_out(r_side)
	);

	cel_div u_div (
		.clk(clk), .arst_n(arst_n), .valid_in(r_valid), .root(root), .side_in(r_side),
		.valid_out(d_valid), .quot_out(quot)
	);

	cel_back u_back (
		.clk(clk), .arst_n(arst_n), .valid_in(d_valid), .quot(quot),
		.valid_out(done), .res(res)
	);

endmodule

[sv/cel_front.sv]
module cel_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  cel_pkg::cel_req_t             req,
	input  logic [cel_pkg::StepW-1:0]     step,
	output logic                          valid_out,
	output logic [cel_pkg::RadW-1:0]      rad_out,
	output cel_pkg::cel_root_side_t       side_out
);

	cel_pkg::cel_req_t req_s1;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	cel_pkg::cel_vals_t vals_s2, vals_s3, vals_s4, vals_s5, vals_s6, vals_s7;
	logic [cel_pkg::RadW-1:0] sqx_s2, sqy_s2, rad_s3, rad_s4, rad_s5, rad_s6, rad_s7;
	logic signed [63:0] p1_s2, p2_s2, tprod_s4;
	logic signed [cel_pkg::ValW-1:0] dot_s3, b_s5;
	logic signed [32:0] diff_s5;
	logic signed [64:0] c_s6;
	logic [cel_pkg::RadW-1:0] dmag_s7;
	logic cneg_s7;
	logic [31:0] mx, my;
	logic [64:0] cabs;

	assign mx = req_s1.offset_x[31] ? 32'(-req_s1.offset_x) : 32'(req_s1.offset_x);
	assign my = req_s1.offset_y[31] ? 32'(-req_s1.offset_y) : 32'(req_s1.offset_y);
	assign cabs = c_s6[64] ? 65'(-c_s6) : 65'(c_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
		vals_s2 <= '{req_s1.self_old, req_s1.center_old, req_s1.center_half,
			req_s1.opposite_old, req_s1.limit_enable};
		sqx_s2 <= 64'(mx) * 64'(mx);
		sqy_s2 <= 64'(my) * 64'(my);
		p1_s2 <= 64'(req_s1.velocity_x) * 64'(req_s1.direction_x);
		p2_s2 <= 64'(req_s1.velocity_y) * 64'(req_s1.direction_y);
		vals_s3 <= vals_s2;
		rad_s3 <= sqx_s2 + sqy_s2;
		dot_s3 <= cel_pkg::sat32(cel_pkg::shr_trunc(65'(p1_s2) + 65'(p2_s2)));
		vals_s4 <= vals_s3;
		rad_s4 <= rad_s3;
		tprod_s4 <= $signed({33'd0, step}) * 64'(dot_s3);
		vals_s5 <= vals_s4;
		rad_s5 <= rad_s4;
		b_s5 <= cel_pkg::sat32(cel_pkg::shr_trunc(65'(tprod_s4)));
		diff_s5 <= 33'(vals_s4.self_old) - 33'(vals_s4.opposite_old);
		vals_s6 <= vals_s5;
		rad_s6 <= rad_s5;
		c_s6 <= 65'(b_s5) * 65'(diff_s5);
		vals_s7 <= vals_s6;
		rad_s7 <= rad_s6;
		dmag_s7 <= cabs[63:0];
		cneg_s7 <= c_s6[64];
	end

	assign valid_out = valid_s7;
	assign rad_out = rad_s7;
	assign side_out = '{vals_s7, dmag_s7, cneg_s7};

endmodule

[sv/cel_sqrt.sv]
module cel_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  logic [cel_pkg::RadW-1:0]  rad,
	input  cel_pkg::cel_root_side_t   side_in,
	output logic                      valid_out,
	output logic [cel_pkg::RootW-1:0] root_out,
	output cel_pkg::cel_root_side_t   side_out
);

	localparam int N = cel_pkg::RootW;

	logic                      valid_s [N];
	logic [cel_pkg::RemW-1:0]  rem_s   [N];
	logic [cel_pkg::RootW-1:0] root_s  [N];
	logic [cel_pkg::RadW-1:0]  rad_s   [N];
	cel_pkg::cel_root_side_t   side_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                      v_i;
		logic [cel_pkg::RemW-1:0]  rem_i, remsh, trial;
		logic [cel_pkg::RootW-1:0] root_i;
		logic [cel_pkg::RadW-1:0]  rad_i;
		cel_pkg::cel_root_side_t   side_i;

		if (k == 0) begin : g_first
			assign v_i = valid_in;
			assign rem_i = '0;
			assign root_i = '0;
			assign rad_i = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i = valid_s[k-1];
			assign rem_i = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i = rad_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign remsh = {rem_i[cel_pkg::RemW-3:0], rad_i[cel_pkg::RadW-1 -: 2]};
		assign trial = cel_pkg::RemW'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (remsh >= trial) begin
				rem_s[k] <= remsh - trial;
				root_s[k] <= {root_i[cel_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_s[k] <= remsh;
				root_s[k] <= {root_i[cel_pkg::RootW-2:0], 1'b0};
			end
			rad_s[k] <= rad_i << 2;
			side_s[k] <= side_i;
		end
	end

	assign valid_out = valid_s[N-1];
	assign root_out = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

[sv/cel_div.sv]
module cel_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  logic [cel_pkg::RootW-1:0] root,
	input  cel_pkg::cel_root_side_t   side_in,
	output logic                      valid_out,
	output cel_pkg::cel_quot_t        quot_out
);

	localparam int N = cel_pkg::RootW;

	logic                      valid_e;
	logic [N-1:0]              h_e, rem_e, low_e;
	cel_pkg::cel_div_side_t    side_e;
	logic                      zero, ovf;

	logic                      valid_s [N];
	logic [N-1:0]              h_s     [N];
	logic [N-1:0]              rem_s   [N];
	logic [N-1:0]              low_s   [N];
	logic [N-1:0]              q_s     [N];
	cel_pkg::cel_div_side_t    side_s  [N];

	assign zero = (root == '0);
	assign ovf = !zero && (side_in.dmag >= {root, {N{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_e <= 1'b0;
		end else begin
			valid_e <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		h_e <= root;
		rem_e <= side_in.dmag[2*N-1:N];
		low_e <= side_in.dmag[N-1:0];
		side_e <= '{side_in.vals, side_in.cneg, ovf, zero};
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                   v_i;
		logic [N-1:0]           h_i, rem_i, low_i, q_i;
		logic [N:0]             remsh, diff;
		cel_pkg::cel_div_side_t side_i;

		if (k == 0) begin : g_first
			assign v_i = valid_e;
			assign h_i = h_e;
			assign rem_i = rem_e;
			assign low_i = low_e;
			assign q_i = '0;
			assign side_i = side_e;
		end else begin : g_next
			assign v_i = valid_s[k-1];
			assign h_i = h_s[k-1];
			assign rem_i = rem_s[k-1];
			assign low_i = low_s[k-1];
			assign q_i = q_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign remsh = {rem_i, low_i[N-1]};
		assign diff = remsh - {1'b0, h_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (remsh >= {1'b0, h_i}) begin
				rem_s[k] <= diff[N-1:0];
				q_s[k] <= {q_i[N-2:0], 1'b1};
			end else begin
				rem_s[k] <= remsh[N-1:0];
				q_s[k] <= {q_i[N-2:0], 1'b0};
			end
			h_s[k] <= h_i;
			low_s[k] <= low_i << 1;
			side_s[k] <= side_i;
		end
	end

	assign valid_out = valid_s[N-1];
	assign quot_out = '{side_s[N-1], q_s[N-1]};

endmodule

[sv/cel_back.sv]
module cel_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  cel_pkg::cel_quot_t quot,
	output logic               valid_out,
	output cel_pkg::cel_res_t  res
);

	localparam int W = cel_pkg::ValW;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [W-1:0] term_s1, m3_s1, x3_s1, m3_s2, x3_s2, tauq_s2;
	logic signed [W:0]   half_s1;
	logic signed [W+1:0] ext_s1, ext_s2;
	logic limit_s1, limit_s2, zero_s1, zero_s2;
	cel_pkg::cel_res_t res_s3;

	cel_pkg::cel_vals_t v;
	logic signed [W+1:0] qs;
	logic signed [W-1:0] term, m3, x3, m3a, x3a;
	logic signed [W:0]   d;
	logic signed [W+2:0] lo, hi, val;
	logic clamp;

	assign v = quot.side.vals;
	assign qs = quot.side.cneg ? -$signed({2'b00, quot.quot}) : $signed({2'b00, quot.quot});
	assign d = (W+1)'(v.center_half) - (W+1)'(v.center_old);
	assign m3a = (v.self_old < v.opposite_old) ? v.self_old : v.opposite_old;
	assign x3a = (v.self_old > v.opposite_old) ? v.self_old : v.opposite_old;
	assign m3 = (v.center_old < m3a) ? v.center_old : m3a;
	assign x3 = (v.center_old > x3a) ? v.center_old : x3a;

	always_comb begin
		priority if (quot.side.zero) begin
			term = '0;
		end else if (quot.side.ovf) begin
			term = quot.side.cneg ? cel_pkg::sat32(cel_pkg::Min32)
				: cel_pkg::sat32(cel_pkg::Max32);
		end else begin
			term = cel_pkg::sat32(65'(qs));
		end
	end

	assign lo = (W+3)'(m3_s2) + (W+3)'(tauq_s2);
	assign hi = (W+3)'(x3_s2) + (W+3)'(tauq_s2);

	always_comb begin
		val = (W+3)'(ext_s2);
		clamp = 1'b0;
		if (limit_s2) begin
			if (val < lo) begin
				val = lo;
				clamp = 1'b1;
			end
			if (val > hi) begin
				val = hi;
				clamp = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		term_s1 <= term;
		half_s1 <= (d + $signed((W+1)'(d[W]))) >>> 1;
		m3_s1 <= m3;
		x3_s1 <= x3;
		ext_s1 <= ((W+2)'(v.center_half) <<< 1) - (W+2)'(v.opposite_old);
		limit_s1 <= v.limit_enable;
		zero_s1 <= quot.side.zero;
		tauq_s2 <= cel_pkg::sat32(65'(half_s1) + 65'(term_s1));
		m3_s2 <= m3_s1;
		x3_s2 <= x3_s1;
		ext_s2 <= ext_s1;
		limit_s2 <= limit_s1;
		zero_s2 <= zero_s1;
		res_s3 <= '{cel_pkg::sat32(65'(val)), clamp, zero_s2};
	end

	assign valid_out = valid_s3;
	assign res = res_s3;

endmodule

[verif/tb_characteristic_extrapolation_limiter_core.sv]
module tb_characteristic_extrapolation_limiter_core;

	localparam int Latency = 75;
	localparam int NumRandom = 1950;
	localparam longint CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cel_pkg::StepW-1:0] cfg_wdata;
	logic start;
	logic busy;
	cel_pkg::cel_req_t req;
	logic done;
	cel_pkg::cel_res_t res;

	logic [cel_pkg::StepW-1:0] tau;
	cel_pkg::cel_res_t expected_q[$];
	int errors;
	int checked;
	int clamp_count;
	int zero_count;
	longint cycles;

	characteristic_extrapolation_limiter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic cel_pkg::cel_res_t limit_node(input cel_pkg::cel_req_t r,
		input logic [cel_pkg::StepW-1:0] step);
		cel_pkg::cel_res_t o;
		longint so, co, ch, oo, h, ext, term, half, tq, lo, hi, m3, x3, dotv, bv;
		longint unsigned mx, my;
		logic signed [127:0] c, dsum;
		so = r.self_old;
		co = r.center_old;
		ch = r.center_half;
		oo = r.opposite_old;
		mx = r.offset_x < 0 ? unsigned'(-longint'(r.offset_x))
			: unsigned'(longint'(r.offset_x));
		my = r.offset_y < 0 ? unsigned'(-longint'(r.offset_y))
			: unsigned'(longint'(r.offset_y));
		h = root_floor(mx * mx + my * my);
		ext = 2 * ch - oo;
		o.clamped = 1'b0;
		o.zero_distance = (h == 0);
		if (r.limit_enable) begin
			term = 0;
			if (h != 0) begin
				dsum = 128'(longint'(r.velocity_x) * longint'(r.direction_x))
					+ 128'(longint'(r.velocity_y) * longint'(r.direction_y));
				dsum = dsum / 128'sd65536;
				dotv = dsum > 128'sd2147483647 ? 64'sd2147483647 :
					dsum < -128'sd2147483648 ? -64'sd2147483648 : longint'(dsum);
				bv = clip32((longint'({1'b0, step}) * dotv) / 64'sd65536);
				c = 128'(bv) * 128'(so - oo);
				c = c / 128'(h);
				term = c > 128'sd2147483647 ? 64'sd2147483647 :
					c < -128'sd2147483648 ? -64'sd2147483648 : longint'(c);
			end
			half = (ch - co) / 2;
			tq = clip32(half + term);
			m3 = so < oo ? so : oo;
			if (co < m3) begin
				m3 = co;
			end
			x3 = so > oo ? so : oo;
			if (co > x3) begin
				x3 = co;
			end
			lo = m3 + tq;
			hi = x3 + tq;
			if (ext < lo) begin
				ext = lo;
				o.clamped = 1'b1;
			end
			if (ext > hi) begin
				ext = hi;
				o.clamped = 1'b1;
			end
		end
		o.new_value = 32'(clip32(ext));
		return o;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 8)) << 16;
			3: return -(32'($urandom_range(0, 8)) << 16);
			4: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
			default: return $urandom();
		endcase
	endfunction

	function automatic cel_pkg::cel_req_t rand_node();
		cel_pkg::cel_req_t r;
		r.self_old = rand_value();
		r.center_old = rand_value();
		r.center_half = rand_value();
		r.opposite_old = rand_value();
		r.offset_x = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_value();
		r.offset_y = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_value();
		r.velocity_x = rand_value();
		r.velocity_y = rand_value();
		r.direction_x = rand_value();
		r.direction_y = rand_value();
		r.limit_enable = ($urandom_range(0, 3) != 0);
		return r;
	endfunction

	task automatic issue(input cel_pkg::cel_req_t r, input bit typed,
		input cel_pkg::cel_res_t want);
		cel_pkg::cel_res_t p;
		p = limit_node(r, tau);
		if (typed && p !== want) begin
			$error("typed value mismatch: expected %h actual prediction %h", want, p);
			errors++;
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_q.push_back(p);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (Latency + 5) @(posedge clk);
	endtask

	task automatic set_step(input logic [cel_pkg::StepW-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tau = v;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
		if (done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result %h", res);
				errors++;
			end else begin
				if (res.new_value !== expected_q[0].new_value) begin
					$error("new_value: expected %h actual %h", expected_q[0].new_value, res.new_value);
					errors++;
				end
				if (res.clamped !== expected_q[0].clamped) begin
					$error("clamped: expected %b actual %b", expected_q[0].clamped, res.clamped);
					errors++;
				end
				if (res.zero_distance !== expected_q[0].zero_distance) begin
					$error("zero_distance: expected %b actual %b",
						expected_q[0].zero_distance, res.zero_distance);
					errors++;
				end
				clamp_count += res.clamped;
				zero_count += res.zero_distance;
				checked++;
				void'(expected_q.pop_front());
			end
		end
	end

	typedef struct {
		cel_pkg::cel_req_t r;
		bit typed;
		cel_pkg::cel_res_t want;
	} node_row_t;

	localparam logic [31:0] Pos = 32'h7fffffff;
	localparam logic [31:0] Neg = 32'h80000000;
	localparam logic [31:0] One = 32'h00010000;

	node_row_t rows[$];

	initial begin
		logic [cel_pkg::StepW-1:0] steps[4];
		int gap_pct;
		errors = 0;
		checked = 0;
		clamp_count = 0;
		zero_count = 0;
		cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		req = '0;
		tau = cel_pkg::StepReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{'{default: '0}, 1'b1, '{32'd0, 1'b0, 1'b1}});
		rows.push_back('{'{0, 0, Pos, Neg, 0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, '{Pos, 1'b0, 1'b1}});
		rows.push_back('{'{0, 0, Neg, Pos, 0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, '{Neg, 1'b0, 1'b1}});
		rows.push_back('{'{0, 0, One, 0, One, 0, 0, 0, 0, 0, 1'b1}, 1'b1,
			'{32'h00008000, 1'b1, 1'b0}});
		rows.push_back('{'{Pos, Pos, Pos, Neg, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, '{Pos, 1'b1, 1'b1}});
		rows.push_back('{'{Neg, Neg, Neg, Pos, Pos, Neg, Pos, Neg, Pos, Neg, 1'b1}, 1'b0, '{default: '0}});
		rows.push_back('{'{Pos, Neg, Pos, Neg, Neg, Neg, Neg, Neg, Neg, Neg, 1'b1}, 1'b0, '{default: '0}});
		rows.push_back('{'{One, 0, One, 0, Neg, 0, Pos, Pos, Pos, Pos, 1'b1}, 1'b0, '{default: '0}});
		rows.push_back('{'{Neg, Pos, 0, Pos, 0, One, Neg, Neg, Neg, Neg, 1'b1}, 1'b0, '{default: '0}});
		rows.push_back('{'{'1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1}, 1'b0, '{default: '0}});

		foreach (rows[i]) begin
			issue(rows[i].r, rows[i].typed, rows[i].want);
		end
		drain();

		steps = '{31'h7fffffff, 31'd1, 31'd65536, 31'd0};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				set_step(ph == 4 ? 31'($urandom()) : steps[ph - 1]);
			end
			for (int n = 0; n < NumRandom / 5; n++) begin
				gap_pct = (ph == 2) ? 0 : 19;
				if ($urandom_range(0, 99) < gap_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				if (n == 100 && ph == 1) begin
					drain();
				end
				issue(rand_node(), 1'b0, '{default: '0});
			end
			drain();
		end

		$display("checked %0d nodes over 5 step sizes; clamps %0d, zero offsets %0d",
			checked, clamp_count, zero_count);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/cel_pkg.sv
sv/cel_front.sv
sv/cel_sqrt.sv
sv/cel_div.sv
sv/cel_back.sv
sv/characteristic_extrapolation_limiter_core.sv
verif/tb_characteristic_extrapolation_limiter_core.sv
